>>> rtl/core/obfr_pkg.sv
package obfr_pkg;

	localparam int CHANNELS    = 4;
	localparam int SAMPLE_BITS = 10;
	localparam int BYTE_BITS   = 8;
	localparam int TIME_BITS   = 16;
	localparam int THR_BITS    = 10;
	localparam int PHASE_BITS  = 4;

	localparam int SAMPLES_W = CHANNELS * SAMPLE_BITS;
	localparam int DATA_W    = CHANNELS * BYTE_BITS;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [BYTE_BITS-1:0]   byte_t;
	typedef logic [TIME_BITS-1:0]   ticks_t;
	typedef logic [THR_BITS-1:0]    thr_t;
	typedef logic [CHANNELS-1:0]    chan_mask_t;
	typedef logic [PHASE_BITS-1:0]  phase_t;
	typedef logic [SAMPLES_W-1:0]   sample_vec_t;
	typedef logic [DATA_W-1:0]      byte_vec_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_BIT_TIME  = 2'd0,
		CFG_BIT_DELAY = 2'd1,
		CFG_THRESHOLD = 2'd2,
		CFG_CH_ENABLE = 2'd3
	} cfg_reg_t;

	localparam ticks_t     BIT_TIME_RST  = 16'd2000;
	localparam ticks_t     BIT_DELAY_RST = 16'd300;
	localparam thr_t       THRESHOLD_RST = 10'd250;
	localparam chan_mask_t CH_ENABLE_RST = '0;

	localparam phase_t PHASE_IDLE      = 4'd0;
	localparam phase_t PHASE_FIRST     = 4'd1;
	localparam phase_t PHASE_LAST_SLOT = 4'd8;
	localparam phase_t PHASE_END       = 4'd9;

endpackage

>>> rtl/core/obfr_if.sv
interface obfr_in_if;
	logic                     valid;
	logic                     ready;
	logic                     operation;
	obfr_pkg::sample_vec_t    samples;

	modport source (output valid, output operation, output samples, input ready);
	modport sink   (input valid, input operation, input samples, output ready);
endinterface

interface obfr_out_if;
	logic                     valid;
	logic                     ready;
	logic                     busy_res;
	logic                     done_res;
	obfr_pkg::byte_vec_t      bit_data;
	obfr_pkg::sample_vec_t    min_levels;
	obfr_pkg::sample_vec_t    max_levels;

	modport source (output valid, output busy_res, output done_res, output bit_data,
		output min_levels, output max_levels, input ready);
	modport sink   (input valid, input busy_res, input done_res, input bit_data,
		input min_levels, input max_levels, output ready);
endinterface

>>> rtl/core/optical_bit_frame_receiver.sv
// Timed multi-channel light receiver.
// The item channel (valid/ready) carries one beat per microsecond: either a
// tick or a start command, each with the current light sample of every
// channel. The result channel returns exactly one beat per item beat, showing
// busy, the done pulse and the per-channel byte, minimum and maximum as they
// stand after that item.
// The configuration port is a plain write port (cfg_we, cfg_index, cfg_data);
// write it only while no beat is in flight (input and result registers empty).
// An accepted item beat passes the input register, then the result register,
// to its result beat. Throughput: one item per cycle while result beats are
// taken; the only loop is the frame state update.
// When the result register holds a beat that is not taken, the input register
// holds too, and the item channel drops ready once that register is full.
// Reset clears the frame state, the per-channel levels and bytes, both valid
// flags, and loads the configuration defaults (bit time 2000, delay 300,
// threshold 250, all channels disabled).
module optical_bit_frame_receiver (
	input  logic                clk,
	input  logic                arst_n,
	obfr_in_if.sink             item,
	obfr_out_if.source          result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	// configuration
	obfr_pkg::ticks_t     bit_time_q;
	obfr_pkg::ticks_t     bit_delay_q;
	obfr_pkg::thr_t       threshold_q;
	obfr_pkg::chan_mask_t ch_enable_q;

	// input register
	logic                    valid_s1;
	logic                    op_s1;
	obfr_pkg::sample_vec_t   samples_s1;

	// frame state
	obfr_pkg::phase_t  phase_q;
	logic              waiting_q;
	obfr_pkg::ticks_t  elapsed_q;
	obfr_pkg::sample_t dark_q [obfr_pkg::CHANNELS];
	obfr_pkg::byte_t   byte_q [obfr_pkg::CHANNELS];
	obfr_pkg::sample_t low_q  [obfr_pkg::CHANNELS];
	obfr_pkg::sample_t high_q [obfr_pkg::CHANNELS];

	// next-state values
	obfr_pkg::phase_t  phase_d;
	logic              waiting_d;
	obfr_pkg::ticks_t  elapsed_d;
	obfr_pkg::sample_t dark_d [obfr_pkg::CHANNELS];
	obfr_pkg::byte_t   byte_d [obfr_pkg::CHANNELS];
	obfr_pkg::sample_t low_d  [obfr_pkg::CHANNELS];
	obfr_pkg::sample_t high_d [obfr_pkg::CHANNELS];
	logic              done_d;
	logic              latch_dark;
	logic              take_slot;
	obfr_pkg::ticks_t  elapsed_inc;
	obfr_pkg::phase_t  phase_dec;
	logic [2:0]        slot_bit;

	// result register
	logic                  out_valid_q;
	logic                  busy_q;
	logic                  done_q;
	obfr_pkg::byte_vec_t   data_q;
	obfr_pkg::sample_vec_t min_q;
	obfr_pkg::sample_vec_t max_q;

	logic advance_s1;
	logic load_s1;

	// Advance the input register into the state and result register when the
	// result register is free or its beat is being taken this cycle.
	assign advance_s1 = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance_s1;
	assign load_s1    = item.valid && item.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_time_q  <= obfr_pkg::BIT_TIME_RST;
			bit_delay_q <= obfr_pkg::BIT_DELAY_RST;
			threshold_q <= obfr_pkg::THRESHOLD_RST;
			ch_enable_q <= obfr_pkg::CH_ENABLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				obfr_pkg::CFG_BIT_TIME:  bit_time_q  <= cfg_data[obfr_pkg::TIME_BITS-1:0];
				obfr_pkg::CFG_BIT_DELAY: bit_delay_q <= cfg_data[obfr_pkg::TIME_BITS-1:0];
				obfr_pkg::CFG_THRESHOLD: threshold_q <= cfg_data[obfr_pkg::THR_BITS-1:0];
				obfr_pkg::CFG_CH_ENABLE: ch_enable_q <= cfg_data[obfr_pkg::CHANNELS-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1      <= item.operation;
			samples_s1 <= item.samples;
		end
	end

	// Frame sequencing: delay, dark latch, then eight sampling slots and a
	// closing interval. Intervals are measured against a running count from
	// which bit_time is subtracted, so rounding never accumulates.
	always_comb begin
		elapsed_inc = elapsed_q + 1'b1;
		phase_dec   = phase_q - 1'b1;
		slot_bit    = phase_dec[2:0];
		phase_d     = phase_q;
		waiting_d   = waiting_q;
		elapsed_d   = elapsed_q;
		done_d      = 1'b0;
		latch_dark  = 1'b0;
		take_slot   = 1'b0;

		if (op_s1 == obfr_pkg::OP_START) begin
			// restart, dropping any frame in progress
			phase_d   = obfr_pkg::PHASE_IDLE;
			elapsed_d = '0;
			waiting_d = 1'b1;
			if (bit_delay_q == '0) begin
				latch_dark = 1'b1;
				waiting_d  = 1'b0;
				phase_d    = obfr_pkg::PHASE_FIRST;
			end
		end else if (waiting_q) begin
			elapsed_d = elapsed_inc;
			if (elapsed_inc >= bit_delay_q) begin
				latch_dark = 1'b1;
				waiting_d  = 1'b0;
				phase_d    = obfr_pkg::PHASE_FIRST;
				elapsed_d  = '0;
			end
		end else if (phase_q != obfr_pkg::PHASE_IDLE) begin
			elapsed_d = elapsed_inc;
			if (elapsed_inc > bit_time_q) begin
				elapsed_d = elapsed_inc - bit_time_q;
				take_slot = (phase_q <= obfr_pkg::PHASE_LAST_SLOT);
				if (phase_q >= obfr_pkg::PHASE_END) begin
					phase_d = obfr_pkg::PHASE_IDLE;
					done_d  = 1'b1;
				end else begin
					phase_d = phase_q + 1'b1;
				end
			end
		end

		// per-channel update; disabled channels hold
		for (int ch = 0; ch < obfr_pkg::CHANNELS; ch++) begin
			obfr_pkg::sample_t            v;
			logic [obfr_pkg::SAMPLE_BITS:0] drop;
			v          = samples_s1[ch*obfr_pkg::SAMPLE_BITS +: obfr_pkg::SAMPLE_BITS];
			drop       = {1'b0, dark_q[ch]} - {1'b0, v};
			dark_d[ch] = dark_q[ch];
			byte_d[ch] = byte_q[ch];
			low_d[ch]  = low_q[ch];
			high_d[ch] = high_q[ch];
			if (ch_enable_q[ch]) begin
				if (latch_dark) begin
					dark_d[ch] = v;
					byte_d[ch] = '0;
					low_d[ch]  = v;
					high_d[ch] = v;
				end else if (take_slot) begin
					if (v > high_q[ch]) high_d[ch] = v;
					if (v < low_q[ch])  low_d[ch]  = v;
					// a one reads as a drop below dark by more than the threshold
					if (!drop[obfr_pkg::SAMPLE_BITS]
							&& (drop[obfr_pkg::SAMPLE_BITS-1:0] > threshold_q)) begin
						byte_d[ch][slot_bit] = 1'b1;
					end
				end
			end
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= obfr_pkg::PHASE_IDLE;
			waiting_q <= 1'b0;
			elapsed_q <= '0;
			for (int ch = 0; ch < obfr_pkg::CHANNELS; ch++) begin
				dark_q[ch] <= '0;
				byte_q[ch] <= '0;
				low_q[ch]  <= '0;
				high_q[ch] <= '0;
			end
		end else if (advance_s1) begin
			phase_q   <= phase_d;
			waiting_q <= waiting_d;
			elapsed_q <= elapsed_d;
			for (int ch = 0; ch < obfr_pkg::CHANNELS; ch++) begin
				dark_q[ch] <= dark_d[ch];
				byte_q[ch] <= byte_d[ch];
				low_q[ch]  <= low_d[ch];
				high_q[ch] <= high_d[ch];
			end
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			busy_q <= waiting_d || (phase_d != obfr_pkg::PHASE_IDLE);
			done_q <= done_d;
			for (int ch = 0; ch < obfr_pkg::CHANNELS; ch++) begin
				data_q[ch*obfr_pkg::BYTE_BITS +: obfr_pkg::BYTE_BITS]     <= byte_d[ch];
				min_q[ch*obfr_pkg::SAMPLE_BITS +: obfr_pkg::SAMPLE_BITS] <= low_d[ch];
				max_q[ch*obfr_pkg::SAMPLE_BITS +: obfr_pkg::SAMPLE_BITS] <= high_d[ch];
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.busy_res   = busy_q;
	assign result.done_res   = done_q;
	assign result.bit_data   = data_q;
	assign result.min_levels = min_q;
	assign result.max_levels = max_q;

endmodule
